@@ hw/rtl/two_stage_break_sequence_detector_assert.svh @@
// Assertion macros used by the escape detector core.
`ifndef TWO_STAGE_BREAK_SEQUENCE_DETECTOR_ASSERT_SVH
`define TWO_STAGE_BREAK_SEQUENCE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSBSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSBSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tsbsd_pkg.sv @@
// Types and constants of the two-stage escape sequence detector.
package tsbsd_pkg;

   // Matching bytes that make up one run.
   localparam logic [2:0] PATTERN_LEN = 3'd6;

   // Register reset values.
   localparam logic [7:0]  FIRST_CHAR_RST   = 8'd64;
   localparam logic [7:0]  SECOND_CHAR_RST  = 8'd33;
   localparam logic [15:0] FIRST_GUARD_RST  = 16'd75;
   localparam logic [15:0] SECOND_GUARD_RST = 16'd50;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_CHAR   = 2'd0,
      CSR_SECOND_CHAR  = 2'd1,
      CSR_FIRST_GUARD  = 2'd2,
      CSR_SECOND_GUARD = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_RUN1   = 2'd0,
      PH_GUARD1 = 2'd1,
      PH_RUN2   = 2'd2,
      PH_GUARD2 = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]  first_char;
      logic [7:0]  second_char;
      logic [15:0] first_guard_ticks;
      logic [15:0] second_guard_ticks;
   } cfg_type;

   typedef struct packed {
      logic      switch_pulse;
      phase_type phase;
      logic [2:0] run_count;
   } result_type;

endpackage

@@ hw/rtl/tsbsd_csr.sv @@
// Configuration registers of the escape detector.
module tsbsd_csr
   import tsbsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_CHAR:   cfg_in.first_char         = csr_write_data[7:0];
            CSR_SECOND_CHAR:  cfg_in.second_char        = csr_write_data[7:0];
            CSR_FIRST_GUARD:  cfg_in.first_guard_ticks  = csr_write_data;
            CSR_SECOND_GUARD: cfg_in.second_guard_ticks = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_char         <= FIRST_CHAR_RST;
         cfg_ff.second_char        <= SECOND_CHAR_RST;
         cfg_ff.first_guard_ticks  <= FIRST_GUARD_RST;
         cfg_ff.second_guard_ticks <= SECOND_GUARD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/tsbsd_core.sv @@
// Escape detector state machine: run counter, guard timer and phase.
module tsbsd_core
   import tsbsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  logic       item_op,
   input  logic [7:0] item_byte,
   input  cfg_type    cfg,
   output result_type result
);

`include "two_stage_break_sequence_detector_assert.svh"

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [15:0] timer_ff;
   logic [15:0] timer_in;
   logic        pulse;

   logic [2:0]  count_inc;
   logic        run_done;
   logic        guard_done;
   logic [7:0]  want_char;

   assign count_inc  = 3'(count_ff + 3'd1);
   assign run_done   = (count_inc >= PATTERN_LEN);
   assign guard_done = (timer_ff <= 16'd1);
   assign want_char  = (phase_ff == PH_RUN1) ? cfg.first_char : cfg.second_char;

   // Next state for one item
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      timer_in = timer_ff;
      pulse    = 1'b0;
      if (step_valid) begin
         if (op_type'(item_op) == OP_BYTE) begin
            unique case (phase_ff)
               PH_RUN1, PH_RUN2: begin
                  if (item_byte == want_char) begin
                     if (run_done) begin
                        count_in = 3'd0;
                        if (phase_ff == PH_RUN1) begin
                           phase_in = PH_GUARD1;
                           timer_in = cfg.first_guard_ticks;
                        end else begin
                           phase_in = PH_GUARD2;
                           timer_in = cfg.second_guard_ticks;
                        end
                     end else begin
                        count_in = count_inc;
                     end
                  end else begin
                     count_in = 3'd0;
                  end
               end
               PH_GUARD1, PH_GUARD2: begin
                  // any byte breaks the silence
                  timer_in = 16'd0;
                  count_in = 3'd0;
                  phase_in = PH_RUN1;
               end
               default: phase_in = phase_ff;
            endcase
         end else begin
            unique case (phase_ff)
               PH_GUARD1, PH_GUARD2: begin
                  if (guard_done) begin
                     timer_in = 16'd0;
                     count_in = 3'd0;
                     if (phase_ff == PH_GUARD1) begin
                        phase_in = PH_RUN2;
                     end else begin
                        phase_in = PH_RUN1;
                        pulse    = 1'b1;
                     end
                  end else begin
                     timer_in = 16'(timer_ff - 16'd1);
                  end
               end
               PH_RUN1, PH_RUN2: phase_in = phase_ff;
               default:          phase_in = phase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RUN1;
         count_ff <= 3'd0;
         timer_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         timer_ff <= timer_in;
      end
   end

   assign result.switch_pulse = pulse;
   assign result.phase        = phase_in;
   assign result.run_count    = count_in;

   `TSBSD_ASSERT_NOW(a_guard_count_zero, clock, reset,
      (phase_ff == PH_GUARD1 || phase_ff == PH_GUARD2), (count_ff == 3'd0),
      "run count not clear during guard")
   `TSBSD_ASSERT_NOW(a_count_below_len, clock, reset,
      1'b1, (count_ff < PATTERN_LEN), "run count reached pattern length")
   `TSBSD_ASSERT_NOW(a_pulse_source, clock, reset,
      pulse, (step_valid && phase_ff == PH_GUARD2 && op_type'(item_op) == OP_TICK),
      "switch pulse outside second guard tick")
   `TSBSD_ASSERT_NEXT(a_byte_breaks_guard, clock, reset,
      (step_valid && op_type'(item_op) == OP_BYTE &&
       (phase_ff == PH_GUARD1 || phase_ff == PH_GUARD2)),
      (phase_ff == PH_RUN1 && timer_ff == 16'd0),
      "byte during guard did not restart")

endmodule

@@ hw/rtl/two_stage_break_sequence_detector.sv @@
// An item goes into the input register, and its result is registered before rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; input and result registers decouple
// the two sides; updating phase, run counter and 16-bit guard timer together sets the rate.
// Reset (synchronous, active high) returns to the first run with registers at defaults.
// Top level of the two-stage escape sequence detector.
module two_stage_break_sequence_detector
   import tsbsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [7:0]             req_data_byte,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_switch_pulse,
   output logic [1:0]             rsp_phase,
   output logic [2:0]             rsp_run_count,
   // configuration
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_pulse_ff;
   logic [1:0] out_phase_ff;
   logic [2:0] out_count_ff;

   logic       out_load;
   logic       advance;
   logic       in_load;

   // Pipeline handshake
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_load ? advance : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_data_byte;
      end
   end

   tsbsd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tsbsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .item_op    (in_op_ff),
      .item_byte  (in_byte_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_pulse_ff <= result.switch_pulse;
         out_phase_ff <= result.phase;
         out_count_ff <= result.run_count;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_switch_pulse = out_pulse_ff;
   assign rsp_phase        = out_phase_ff;
   assign rsp_run_count    = out_count_ff;

endmodule
